// ===== rtl/core/b64sd_pkg.sv =====
// Shared types, constants and the character classifier for the base64 stream decoder.
package b64sd_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned SymW  = 6;
  localparam int unsigned DataW = 8;
  localparam int unsigned CntW  = 2;

  // Padding stores the low six bits of the '=' code in slot three.
  localparam logic [SymW-1:0] PAD_SYM = 6'h3D;

  typedef enum logic [1:0] {
    KIND_SYM  = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_SKIP = 2'd2
  } b64sd_kind_t;

  typedef struct packed {
    b64sd_kind_t     kind;
    logic [SymW-1:0] value;
  } b64sd_class_t;

  // One decoded run: up to three bytes, count is 1..3.
  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [DataW-1:0] data2;
    logic [DataW-1:0] data1;
    logic [DataW-1:0] data0;
  } b64sd_job_t;

  typedef struct packed {
    logic       push;
    b64sd_job_t job;
  } b64sd_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64sd_qstat_t;

  function automatic b64sd_class_t b64sd_classify(input logic [DataW-1:0] c);
    b64sd_class_t r;
    r.kind  = KIND_SKIP;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.kind  = KIND_SYM;
      r.value = SymW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.kind  = KIND_SYM;
      r.value = SymW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.kind  = KIND_SYM;
      r.value = SymW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.kind  = KIND_SYM;
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.kind  = KIND_SYM;
      r.value = 6'd63;
    end else if (c == 8'h3D) begin
      r.kind  = KIND_PAD;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/b64sd_front.sv =====
// Front end: classifies characters, tracks the symbol group and forms decoded runs.
module b64sd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [b64sd_pkg::DataW-1:0] in_char_code,
  input  logic                      in_start_of_string,
  input  b64sd_pkg::b64sd_qstat_t   qstat,
  output b64sd_pkg::b64sd_push_t    qpush
);
  import b64sd_pkg::*;

  logic [3:0][SymW-1:0] grp_r, grp_nxt;
  logic [1:0]           pos_r, pos_nxt;
  logic                 stopped_r, stopped_nxt;

  logic                 accept;
  logic [1:0]           pos_eff;
  logic                 stop_eff;
  b64sd_class_t         cls;
  logic                 emit;
  logic [CntW-1:0]      count;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign cls      = b64sd_classify(in_char_code);
  assign pos_eff  = in_start_of_string ? 2'd0 : pos_r;
  assign stop_eff = in_start_of_string ? 1'b0 : stopped_r;

  always_comb begin
    grp_nxt     = grp_r;
    pos_nxt     = pos_eff;
    stopped_nxt = stop_eff;
    emit        = 1'b0;
    count       = 2'd3;
    if (!stop_eff) begin
      unique case (cls.kind)
        KIND_SYM: begin
          grp_nxt[pos_eff] = cls.value;
          if (pos_eff == 2'd3) begin
            emit    = 1'b1;
            pos_nxt = 2'd0;
          end else begin
            pos_nxt = pos_eff + 2'd1;
          end
        end
        KIND_PAD: begin
          stopped_nxt = 1'b1;
          pos_nxt     = 2'd0;
          if (pos_eff != 2'd0) begin
            grp_nxt[3] = PAD_SYM;
            emit       = 1'b1;
            count      = (pos_eff == 2'd3) ? 2'd2 : 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    qpush.push      = accept && emit;
    qpush.job.count = count;
    qpush.job.data0 = {grp_nxt[0], grp_nxt[1][5:4]};
    qpush.job.data1 = {grp_nxt[1][3:0], grp_nxt[2][5:2]};
    qpush.job.data2 = {grp_nxt[2][1:0], grp_nxt[3]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r     <= '0;
      pos_r     <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      grp_r     <= grp_nxt;
      pos_r     <= pos_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== rtl/core/b64sd_queue.sv =====
// Short FIFO of decoded runs between front and back end.
module b64sd_queue #(
  parameter int unsigned DEPTH = b64sd_pkg::QueueDepthDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  b64sd_pkg::b64sd_push_t  qpush,
  input  logic                    pop,
  output b64sd_pkg::b64sd_job_t   head,
  output b64sd_pkg::b64sd_qstat_t qstat
);
  import b64sd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(DEPTH);

  b64sd_job_t      mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OccW-1:0] occ_r, occ_nxt;
  logic            do_push, do_pop;

  assign qstat.full  = (occ_r == FullOcc);
  assign qstat.empty = (occ_r == '0);
  assign do_push     = qpush.push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (do_pop && !do_push) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= qpush.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

endmodule

// ===== rtl/core/b64sd_back.sv =====
// Back end: unpacks queued runs into one output byte per request.
module b64sd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  b64sd_pkg::b64sd_job_t       head,
  input  b64sd_pkg::b64sd_qstat_t     qstat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b64sd_pkg::DataW-1:0] out_data_byte,
  output logic                        out_last_of_run
);
  import b64sd_pkg::*;

  logic [CntW-1:0]  left_r, left_nxt;
  logic [DataW-1:0] d0_r, d0_nxt;
  logic [DataW-1:0] d1_r, d1_nxt;
  logic [DataW-1:0] d2_r, d2_nxt;
  logic             done;

  assign out_valid       = (left_r != '0);
  assign out_data_byte   = d0_r;
  assign out_last_of_run = (left_r == 2'd1);

  // Refill once the register is empty or its final byte leaves this cycle.
  assign done = (left_r == '0) || (out_ready && left_r == 2'd1);
  assign pop  = done && !qstat.empty;

  always_comb begin
    left_nxt = left_r;
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    if (pop) begin
      left_nxt = head.count;
      d0_nxt   = head.data0;
      d1_nxt   = head.data1;
      d2_nxt   = head.data2;
    end else if (done) begin
      left_nxt = '0;
    end else if (out_ready) begin
      // Advance to the next byte of the run.
      left_nxt = left_r - 2'd1;
      d0_nxt   = d1_r;
      d1_nxt   = d2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
    d2_r <= d2_nxt;
  end

endmodule

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// Top level of the streaming base64 decoder: front end, run queue and byte output.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_char_code[7:0], in_start_of_string
//   out_     output     out_valid/out_ready  out_data_byte[7:0], out_last_of_run
//
// One character is taken per cycle while the run queue has room; a full group
// becomes one queue entry the same cycle it completes.
// The output register sends one byte per cycle while out_ready is high; four
// characters per three bytes keeps the pace at one character per cycle.
// Reset (rst_n, synchronous) empties queue and group.
// With out_ready low the output register holds one run and the queue fills
// after QUEUE_DEPTH more, so in_ready drops after QUEUE_DEPTH + 1 runs.
module base64_stream_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = b64sd_pkg::QueueDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [b64sd_pkg::DataW-1:0] in_char_code,
  input  logic                        in_start_of_string,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b64sd_pkg::DataW-1:0] out_data_byte,
  output logic                        out_last_of_run
);
  import b64sd_pkg::*;

  b64sd_push_t  qpush;
  b64sd_qstat_t qstat;
  b64sd_job_t   head;
  logic         pop;

  b64sd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .in_start_of_string (in_start_of_string),
    .qstat              (qstat),
    .qpush              (qpush)
  );

  b64sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  b64sd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .qstat           (qstat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== test/base64_stream_decoder_unit_tb.sv =====
// Self-checking testbench for the base64 stream decoder: directed table, then random strings.
module base64_stream_decoder_unit_tb;
  import b64sd_pkg::*;

  localparam int RAND_ITEMS = 390;
  localparam int CALM_TAIL  = 60;
  localparam int LONG_HOLD  = 300;
  localparam int QUIET_MAX  = 2000;
  localparam int DRAIN      = 20;
  localparam int MAX_SHOWN  = 10;

  localparam logic [7:0] CH_PAD = 8'h3D;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_exp_t;

  // One directed request; typed rows carry their own expected bytes.
  typedef struct packed {
    logic [7:0] ch;
    logic       sos;
    logic       typed;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{CH_PAD, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // pad with empty group
    '{8'h41,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // ignored while stopped
    '{8'h41,  1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{CH_PAD, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},  // lone symbol, slot one still zero
    '{8'h2F,  1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h2F,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h2F,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h2F,  1'b0, 1'b1, 2'd3, 8'hFF, 8'hFF, 8'hFF},
    '{8'h41,  1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h41,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h41,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h41,  1'b0, 1'b1, 2'd3, 8'h00, 8'h00, 8'h00},
    '{8'h7A,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h39,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h2B,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{CH_PAD, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},  // pad after three symbols
    '{8'h00,  1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // skipped, but start still clears
    '{8'hFF,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h80,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h5A,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{CH_PAD, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},  // lone symbol meets stale slot one
    '{8'h30,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h61,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h42,  1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},  // partial group dropped
    '{8'h2D,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       in_start_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_last_of_run;

  base64_stream_decoder_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .in_start_of_string (in_start_of_string),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_last_of_run    (out_last_of_run)
  );

  // Decoder state as predicted.
  logic [5:0] grp [4] = '{default: 6'd0};
  logic [1:0] gpos = 2'd0;
  logic       halted = 1'b0;

  byte_exp_t  exp_bytes [$];
  int         err_cnt = 0;
  int         chars_sent = 0;
  int         symbols_taken = 0;
  int         bytes_checked = 0;
  int         strings_sent = 0;
  bit         idle_on = 1'b1;
  bit         long_hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("ERROR: %s", msg);
  endtask

  function automatic b64sd_class_t char_class(input logic [7:0] c);
    b64sd_class_t r;
    r.kind  = KIND_SKIP;
    r.value = '0;
    if (c >= "A" && c <= "Z") begin
      r.kind  = KIND_SYM;
      r.value = 6'(c - 8'd65);
    end else if (c >= "a" && c <= "z") begin
      r.kind  = KIND_SYM;
      r.value = 6'(c - 8'd71);
    end else if (c >= "0" && c <= "9") begin
      r.kind  = KIND_SYM;
      r.value = 6'(c + 8'd4);
    end else if (c == "+") begin
      r.kind  = KIND_SYM;
      r.value = 6'd62;
    end else if (c == "/") begin
      r.kind  = KIND_SYM;
      r.value = 6'd63;
    end else if (c == CH_PAD) begin
      r.kind  = KIND_PAD;
    end
    return r;
  endfunction

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    if (v < 6'd26) return 8'd65 + 8'(v);
    if (v < 6'd52) return 8'd71 + 8'(v);
    if (v < 6'd62) return 8'(v) - 8'd4;
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  function automatic logic [7:0] skip_byte();
    logic [7:0]   c;
    b64sd_class_t cl;
    do begin
      c  = 8'($urandom_range(0, 255));
      cl = char_class(c);
    end while (cl.kind != KIND_SKIP);
    return c;
  endfunction

  // Advance the predicted state by one character and return the bytes it releases.
  task automatic decode_char(input logic [7:0] c, input logic sos, output logic [1:0] n,
                             output logic [2:0][7:0] run, output bit took);
    b64sd_class_t cl;
    logic [1:0]   p;
    n    = 2'd0;
    run  = '0;
    took = 1'b0;
    if (sos) begin
      gpos   = 2'd0;
      halted = 1'b0;
    end
    if (halted) return;
    cl = char_class(c);
    if (cl.kind == KIND_SKIP) return;
    took = 1'b1;
    p = gpos;
    if (cl.kind == KIND_PAD) begin
      halted = 1'b1;
      if (p == 2'd0) return;
      n      = (p == 2'd3) ? 2'd2 : 2'd1;
      grp[3] = PAD_SYM;
      gpos   = 2'd0;
    end else begin
      grp[p] = cl.value;
      gpos   = p + 2'd1;
      if (p != 2'd3) return;
      n = 2'd3;
    end
    run[0] = {grp[0], grp[1][5:4]};
    run[1] = {grp[1][3:0], grp[2][5:2]};
    run[2] = {grp[2][1:0], grp[3]};
  endtask

  // Queue the expected bytes, then offer the request until it is taken.
  task automatic send_char(input logic [7:0] c, input logic sos, input bit typed = 1'b0,
                           input logic [1:0] typed_n = 2'd0,
                           input logic [2:0][7:0] typed_run = '0);
    logic [1:0]      n;
    logic [2:0][7:0] run;
    bit              took;
    decode_char(c, sos, n, run, took);
    if (typed) begin
      n   = typed_n;
      run = typed_run;
    end
    for (int k = 0; k < int'(n); k++) exp_bytes.push_back('{run[k], k == int'(n) - 1});
    if (took) symbols_taken++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_char_code       <= c;
    in_start_of_string <= sos;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  initial begin : receiver
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    byte_exp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (exp_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %02h last %0b", out_data_byte, out_last_of_run));
      end else begin
        e = exp_bytes.pop_front();
        bytes_checked++;
        if (out_data_byte !== e.data || out_last_of_run !== e.last)
          note_error($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                               bytes_checked, e.data, e.last, out_data_byte, out_last_of_run));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes outstanding", quiet,
               exp_bytes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int  base;
    int  ngrp;
    int  tail;
    int  nsym;
    int  npad;
    bit  first;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (dir_tab[i])
      send_char(dir_tab[i].ch, dir_tab[i].sos, dir_tab[i].typed, dir_tab[i].n,
                {dir_tab[i].b2, dir_tab[i].b1, dir_tab[i].b0});

    // Stall the output for a long stretch while strings keep coming.
    long_hold_req = 1'b1;
    base = chars_sent;
    while (chars_sent - base < RAND_ITEMS) begin
      if (RAND_ITEMS - (chars_sent - base) < CALM_TAIL) idle_on = 1'b0;
      if ($urandom_range(0, 9) < 8) begin
        strings_sent++;
        ngrp  = $urandom_range(0, 3);
        tail  = $urandom_range(0, 3);
        nsym  = 4 * ngrp + tail;
        first = 1'b1;
        for (int k = 0; k < nsym; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_char(skip_byte(), first);
            first = 1'b0;
          end
          send_char(sym_char(6'($urandom_range(0, 63))), first);
          first = 1'b0;
        end
        if (tail != 0 || $urandom_range(0, 3) == 0) begin
          npad = $urandom_range(1, 2);
          repeat (npad) begin
            send_char(CH_PAD, first);
            first = 1'b0;
          end
        end
        // Trailing bytes: dropped after a pad, otherwise part of the string.
        if ($urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (exp_bytes.size() != 0)
      note_error($sformatf("%0d expected bytes never arrived", exp_bytes.size()));

    $display("Sent %0d characters (%0d symbols or pads taken) in %0d random strings plus noise,",
             chars_sent, symbols_taken, strings_sent);
    $display("compared %0d decoded bytes, %0d mismatches in total.", bytes_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
